FILE: src/i2cbm_pkg.sv
// Package for the I2C byte master: sequencer phase codes, command, status and
// register codes, and the control and result structs shared by the step logic and top.
// No dependencies.
package i2cbm_pkg;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_NACK    = 2'd2;

  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  localparam int unsigned HALF_PERIOD_RESET    = 5;
  localparam int unsigned STRETCH_TIMEOUT_RESET = 10000;

  localparam int unsigned BITS_PER_BYTE = 8;

  typedef enum logic [25:0] {
    PH_IDLE  = 26'h0000001,
    PH_ST_W  = 26'h0000002,
    PH_ST_D1 = 26'h0000004,
    PH_ST_D2 = 26'h0000008,
    PH_ST_D3 = 26'h0000010,
    PH_ST_D4 = 26'h0000020,
    PH_SP_D1 = 26'h0000040,
    PH_SP_D2 = 26'h0000080,
    PH_SP_W  = 26'h0000100,
    PH_SP_D3 = 26'h0000200,
    PH_SP_D4 = 26'h0000400,
    PH_WR_D1 = 26'h0000800,
    PH_WR_W  = 26'h0001000,
    PH_WR_D2 = 26'h0002000,
    PH_WR_D3 = 26'h0004000,
    PH_WA_D1 = 26'h0008000,
    PH_WA_W  = 26'h0010000,
    PH_WA_D2 = 26'h0020000,
    PH_WA_D3 = 26'h0040000,
    PH_RD_W  = 26'h0080000,
    PH_RD_D1 = 26'h0100000,
    PH_RD_D2 = 26'h0200000,
    PH_RA_D1 = 26'h0400000,
    PH_RA_W  = 26'h0800000,
    PH_RA_D2 = 26'h1000000,
    PH_RA_D3 = 26'h2000000
  } phase_t;

  // Sequencer state other than the two tick counters
  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [2:0] active_command;
    logic       ack_to_send;
    logic [1:0] pending_status;
    logic       scl_drv;
    logic       sda_drv;
  } ctl_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } result_t;

endpackage

FILE: src/i2cbm_in_if.sv
// Input channel of the I2C byte master: one bus tick item per handshake.
// Standalone valid/ready interface, no package dependency.
interface i2cbm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       scl_in;
  logic       sda_in;

  modport source (output valid, kind, tx_byte, send_ack, scl_in, sda_in, input ready);
  modport sink   (input valid, kind, tx_byte, send_ack, scl_in, sda_in, output ready);
endinterface

FILE: src/i2cbm_out_if.sv
// Result channel of the I2C byte master: line drive and command status per tick.
// Standalone valid/ready interface, no package dependency.
interface i2cbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic [1:0] status;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  status, input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  status, output ready);
endinterface

FILE: src/i2cbm_step.sv
// Next-state logic of the I2C byte sequencer for one bus tick.
// Uses i2cbm_pkg for the phase codes and the control and result structs.
module i2cbm_step #(
  parameter int DELAY_WIDTH   = 16,
  parameter int TIMEOUT_WIDTH = 20
) (
  input  i2cbm_pkg::ctl_t         st,
  input  logic [DELAY_WIDTH-1:0]   delay_count,
  input  logic [TIMEOUT_WIDTH-1:0] stretch_count,
  input  logic [DELAY_WIDTH-1:0]   half_period,
  input  logic [TIMEOUT_WIDTH-1:0] stretch_timeout,
  input  logic [2:0]               kind,
  input  logic [7:0]               tx_byte,
  input  logic                     send_ack,
  input  logic                     scl_in,
  input  logic                     sda_in,
  output i2cbm_pkg::ctl_t         st_nxt,
  output logic [DELAY_WIDTH-1:0]   delay_nxt,
  output logic [TIMEOUT_WIDTH-1:0] stretch_nxt,
  output i2cbm_pkg::result_t      res
);
  import i2cbm_pkg::*;

  logic [DELAY_WIDTH-1:0]   d_inc;
  logic [TIMEOUT_WIDTH-1:0] s_inc;
  logic                     d_hit;
  logic                     s_tmo;
  logic                     go_en;
  phase_t                   go_ph;
  logic                     fin;
  logic [1:0]               fin_st;
  ctl_t                     n;

  // Saturating tick counters
  assign d_inc = (delay_count != '1) ? delay_count + DELAY_WIDTH'(1) : delay_count;
  assign s_inc = (stretch_count != '1) ? stretch_count + TIMEOUT_WIDTH'(1) : stretch_count;
  assign d_hit = (d_inc >= half_period);
  assign s_tmo = (s_inc >= stretch_timeout);

  always_comb begin
    n           = st;
    delay_nxt   = delay_count;
    stretch_nxt = stretch_count;
    go_en       = 1'b0;
    go_ph       = PH_IDLE;
    fin         = 1'b0;
    fin_st      = STAT_OK;

    case (st.phase)
      PH_IDLE: begin
        if (kind == CMD_START || kind == CMD_STOP || kind == CMD_WRITE || kind == CMD_READ) begin
          n.active_command = kind;
          n.shift_reg      = tx_byte;
          n.ack_to_send    = send_ack;
          n.bit_count      = 4'd0;
          n.pending_status = STAT_OK;
          go_en            = 1'b1;
          if (kind == CMD_START) begin
            n.sda_drv = 1'b1;
            n.scl_drv = 1'b1;
            go_ph     = PH_ST_W;
          end else if (kind == CMD_STOP) begin
            n.scl_drv = 1'b0;
            go_ph     = PH_SP_D1;
          end else if (kind == CMD_WRITE) begin
            n.sda_drv = tx_byte[7];
            go_ph     = PH_WR_D1;
          end else begin
            n.shift_reg = 8'd0;
            n.sda_drv   = 1'b1;
            n.scl_drv   = 1'b1;
            go_ph       = PH_RD_W;
          end
        end
      end
      PH_ST_W: begin
        if (scl_in) begin
          go_en = 1'b1; go_ph = PH_ST_D1;
        end else begin
          stretch_nxt = s_inc;
          if (s_tmo) begin
            go_en = 1'b1; go_ph = PH_ST_D2;
          end
        end
      end
      PH_ST_D1: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          go_en = 1'b1; go_ph = PH_ST_D2;
        end
      end
      PH_ST_D2: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.sda_drv = 1'b0; go_en = 1'b1; go_ph = PH_ST_D3;
        end
      end
      PH_ST_D3: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv = 1'b0; go_en = 1'b1; go_ph = PH_ST_D4;
        end
      end
      PH_ST_D4: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          fin = 1'b1; fin_st = STAT_OK; go_en = 1'b1; go_ph = PH_IDLE;
        end
      end
      PH_SP_D1: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.sda_drv = 1'b0; go_en = 1'b1; go_ph = PH_SP_D2;
        end
      end
      PH_SP_D2: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv = 1'b1; go_en = 1'b1; go_ph = PH_SP_W;
        end
      end
      PH_SP_W: begin
        if (scl_in) begin
          go_en = 1'b1; go_ph = PH_SP_D3;
        end else begin
          stretch_nxt = s_inc;
          if (s_tmo) begin
            n.sda_drv = 1'b1; go_en = 1'b1; go_ph = PH_SP_D4;
          end
        end
      end
      PH_SP_D3: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.sda_drv = 1'b1; go_en = 1'b1; go_ph = PH_SP_D4;
        end
      end
      PH_SP_D4: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          fin = 1'b1; fin_st = st.pending_status; go_en = 1'b1; go_ph = PH_IDLE;
        end
      end
      PH_WR_D1: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv = 1'b1; go_en = 1'b1; go_ph = PH_WR_W;
        end
      end
      PH_WR_W: begin
        if (scl_in) begin
          go_en = 1'b1; go_ph = PH_WR_D2;
        end else begin
          stretch_nxt = s_inc;
          // Timeout: pull SCL low and issue a stop
          if (s_tmo) begin
            n.pending_status = STAT_TIMEOUT;
            n.scl_drv        = 1'b0;
            go_en            = 1'b1;
            go_ph            = PH_SP_D1;
          end
        end
      end
      PH_WR_D2: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv   = 1'b0;
          n.shift_reg = {st.shift_reg[6:0], 1'b0};
          n.bit_count = st.bit_count + 4'd1;
          go_en       = 1'b1;
          go_ph       = PH_WR_D3;
        end
      end
      PH_WR_D3: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          go_en = 1'b1;
          if (st.bit_count < 4'(BITS_PER_BYTE)) begin
            n.sda_drv = st.shift_reg[7];
            go_ph     = PH_WR_D1;
          end else begin
            n.sda_drv = 1'b1;
            go_ph     = PH_WA_D1;
          end
        end
      end
      PH_WA_D1: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv = 1'b1; go_en = 1'b1; go_ph = PH_WA_W;
        end
      end
      PH_WA_W: begin
        if (scl_in) begin
          go_en = 1'b1; go_ph = PH_WA_D2;
        end else begin
          stretch_nxt = s_inc;
          if (s_tmo) begin
            n.pending_status = STAT_TIMEOUT;
            n.scl_drv        = 1'b0;
            go_en            = 1'b1;
            go_ph            = PH_SP_D1;
          end
        end
      end
      PH_WA_D2: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.pending_status = sda_in ? STAT_NACK : STAT_OK;
          n.scl_drv        = 1'b0;
          go_en            = 1'b1;
          go_ph            = PH_WA_D3;
        end
      end
      PH_WA_D3: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.sda_drv = 1'b1;
          go_en     = 1'b1;
          if (st.pending_status == STAT_NACK) begin
            n.scl_drv = 1'b0;
            go_ph     = PH_SP_D1;
          end else begin
            fin    = 1'b1;
            fin_st = STAT_OK;
            go_ph  = PH_IDLE;
          end
        end
      end
      PH_RD_W: begin
        if (scl_in) begin
          go_en = 1'b1; go_ph = PH_RD_D1;
        end else begin
          stretch_nxt = s_inc;
          // Timeout: return the partial byte at once
          if (s_tmo) begin
            n.scl_drv = 1'b0;
            fin       = 1'b1;
            fin_st    = STAT_TIMEOUT;
            go_en     = 1'b1;
            go_ph     = PH_IDLE;
          end
        end
      end
      PH_RD_D1: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.shift_reg = {st.shift_reg[7:1], st.shift_reg[0] | sda_in};
          n.scl_drv   = 1'b0;
          n.bit_count = st.bit_count + 4'd1;
          go_en       = 1'b1;
          go_ph       = PH_RD_D2;
        end
      end
      PH_RD_D2: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          go_en = 1'b1;
          if (st.bit_count < 4'(BITS_PER_BYTE)) begin
            n.shift_reg = {st.shift_reg[6:0], 1'b0};
            n.scl_drv   = 1'b1;
            go_ph       = PH_RD_W;
          end else begin
            n.sda_drv = ~st.ack_to_send;
            go_ph     = PH_RA_D1;
          end
        end
      end
      PH_RA_D1: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv = 1'b1; go_en = 1'b1; go_ph = PH_RA_W;
        end
      end
      PH_RA_W: begin
        if (scl_in) begin
          go_en = 1'b1; go_ph = PH_RA_D2;
        end else begin
          stretch_nxt = s_inc;
          if (s_tmo) begin
            n.scl_drv = 1'b0; go_en = 1'b1; go_ph = PH_RA_D3;
          end
        end
      end
      PH_RA_D2: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.scl_drv = 1'b0; go_en = 1'b1; go_ph = PH_RA_D3;
        end
      end
      PH_RA_D3: begin
        delay_nxt = d_inc;
        if (d_hit) begin
          n.sda_drv = 1'b1;
          fin       = 1'b1;
          fin_st    = STAT_OK;
          go_en     = 1'b1;
          go_ph     = PH_IDLE;
        end
      end
      default: begin
        go_en = 1'b1;
        go_ph = PH_IDLE;
      end
    endcase

    // Phase change clears both tick counters
    if (go_en) begin
      n.phase     = go_ph;
      delay_nxt   = '0;
      stretch_nxt = '0;
    end
    st_nxt = n;

    res.scl_release = n.scl_drv;
    res.sda_release = n.sda_drv;
    res.busy_res    = (n.phase != PH_IDLE);
    res.done_res    = fin;
    res.rx_byte     = (fin && n.active_command == CMD_READ) ? n.shift_reg : 8'd0;
    res.status      = fin ? fin_st : STAT_OK;
  end

endmodule

FILE: src/i2c_byte_master_with_stretch_timeout_core.sv
// I2C byte master with clock-stretch timeout: top level.
// An accepted item passes through the input register, then the sequencer step into
// the result register. Throughput: one item per cycle while the result channel
// is not stalled by out_ch.ready.
// Reset (synchronous, rst_n low): sequencer idle, both lines released,
// half period 5 ticks, stretch timeout 10000 ticks, both channels empty.
module i2c_byte_master_with_stretch_timeout_core #(
  parameter int DELAY_WIDTH   = 16,
  parameter int TIMEOUT_WIDTH = 20
) (
  input  logic clk,
  input  logic rst_n,
  i2cbm_in_if.sink    in_ch,
  i2cbm_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [((DELAY_WIDTH > TIMEOUT_WIDTH) ? DELAY_WIDTH : TIMEOUT_WIDTH)-1:0] cfg_wdata
);
  import i2cbm_pkg::*;

  logic [DELAY_WIDTH-1:0]   half_period_r;
  logic [TIMEOUT_WIDTH-1:0] stretch_timeout_r;

  // Input register
  logic       s1_valid_r;
  logic [2:0] kind_r;
  logic [7:0] tx_byte_r;
  logic       send_ack_r;
  logic       scl_in_r;
  logic       sda_in_r;

  // Sequencer state
  ctl_t                     ctl_r;
  ctl_t                     ctl_nxt;
  logic [DELAY_WIDTH-1:0]   delay_r;
  logic [DELAY_WIDTH-1:0]   delay_nxt;
  logic [TIMEOUT_WIDTH-1:0] stretch_r;
  logic [TIMEOUT_WIDTH-1:0] stretch_nxt;

  // Result register
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;

  logic adv;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r     <= DELAY_WIDTH'(HALF_PERIOD_RESET);
      stretch_timeout_r <= TIMEOUT_WIDTH'(STRETCH_TIMEOUT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period_r     <= cfg_wdata[DELAY_WIDTH-1:0];
        REG_TIMEOUT:     stretch_timeout_r <= cfg_wdata[TIMEOUT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r     <= in_ch.kind;
      tx_byte_r  <= in_ch.tx_byte;
      send_ack_r <= in_ch.send_ack;
      scl_in_r   <= in_ch.scl_in;
      sda_in_r   <= in_ch.sda_in;
    end
  end

  i2cbm_step #(
    .DELAY_WIDTH   (DELAY_WIDTH),
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_step (
    .st              (ctl_r),
    .delay_count     (delay_r),
    .stretch_count   (stretch_r),
    .half_period     (half_period_r),
    .stretch_timeout (stretch_timeout_r),
    .kind            (kind_r),
    .tx_byte         (tx_byte_r),
    .send_ack        (send_ack_r),
    .scl_in          (scl_in_r),
    .sda_in          (sda_in_r),
    .st_nxt          (ctl_nxt),
    .delay_nxt       (delay_nxt),
    .stretch_nxt     (stretch_nxt),
    .res             (res_nxt)
  );

  // Advance the sequencer only when the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase          <= PH_IDLE;
      ctl_r.bit_count      <= 4'd0;
      ctl_r.shift_reg      <= 8'd0;
      ctl_r.active_command <= CMD_NONE;
      ctl_r.ack_to_send    <= 1'b0;
      ctl_r.pending_status <= STAT_OK;
      ctl_r.scl_drv        <= 1'b1;
      ctl_r.sda_drv        <= 1'b1;
      delay_r              <= '0;
      stretch_r            <= '0;
      out_valid_r          <= 1'b0;
    end else begin
      if (adv) begin
        ctl_r       <= ctl_nxt;
        delay_r     <= delay_nxt;
        stretch_r   <= stretch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_release = res_r.scl_release;
  assign out_ch.sda_release = res_r.sda_release;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.rx_byte     = res_r.rx_byte;
  assign out_ch.status      = res_r.status;

endmodule
